>>> sv/dsm_pkg.sv
package dsm_pkg;

  // Port width of push_value and element_value.
  localparam int unsigned ValueInW      = 8;
  // Widest stored value supported.
  localparam int unsigned MaxValueW     = 32;
  localparam int unsigned DefStackDepth = 64;
  localparam int unsigned DefValueWidth = 8;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_DUMP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_DUMP = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic                sel;
    logic [ValueInW-1:0] value;
  } cmd_t;

endpackage

>>> sv/dual_stack_manager_unit.sv
// Two LIFO stacks, A and B, driven by one command stream. A command beat is
// taken when start_i is high and busy_o is low; push and pop give no result,
// a dump gives one result beat per entry, bottom first, with last_of_dump_o
// on the final beat (an empty stack gives a single beat with stack_empty_o
// set and a zero value). Results appear for exactly one cycle under
// result_valid_o and cannot be stalled. Commands pass through a two-entry
// queue into the execute side: push and pop are done when the command is
// taken; a dump of n entries is taken and then gives one shared memory read
// per cycle, data registered, or a single beat when empty. busy_o rises only
// when the queue is full. Push to a full stack, pop from an empty one and
// operation code 3 are taken and have no effect.
module dual_stack_manager_unit #(
  parameter int unsigned STACK_DEPTH = dsm_pkg::DefStackDepth,
  parameter int unsigned VALUE_WIDTH = dsm_pkg::DefValueWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   operation_i,
  input  logic                         stack_select_i,
  input  logic [dsm_pkg::ValueInW-1:0] push_value_i,
  output logic                         result_valid_o,
  output logic                         stack_id_o,
  output logic [dsm_pkg::ValueInW-1:0] element_value_o,
  output logic                         stack_empty_o,
  output logic                         last_of_dump_o
);
  import dsm_pkg::*;

  // front to back
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  dsm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .stack_select_i (stack_select_i),
    .push_value_i   (push_value_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_take_i     (cmd_take)
  );

  dsm_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_take_o      (cmd_take),
    .result_valid_o  (result_valid_o),
    .stack_id_o      (stack_id_o),
    .element_value_o (element_value_o),
    .stack_empty_o   (stack_empty_o),
    .last_of_dump_o  (last_of_dump_o)
  );

endmodule

>>> sv/dsm_front.sv
module dsm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   operation_i,
  input  logic                         stack_select_i,
  input  logic [dsm_pkg::ValueInW-1:0] push_value_i,
  output logic                         cmd_valid_o,
  output dsm_pkg::cmd_t                cmd_o,
  input  logic                         cmd_take_i
);
  import dsm_pkg::*;

  // Classified command and whether it does anything at all.
  cmd_t cls_cmd;
  logic cls_keep;

  // Two-entry command queue.
  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  always_comb begin
    cls_cmd.sel   = stack_select_i;
    cls_cmd.value = push_value_i;
    cls_cmd.kind  = CMD_PUSH;
    cls_keep      = 1'b1;
    case (op_e'(operation_i))
      OP_PUSH: cls_cmd.kind = CMD_PUSH;
      OP_POP:  cls_cmd.kind = CMD_POP;
      OP_DUMP: cls_cmd.kind = CMD_DUMP;
      default: cls_keep = 1'b0;  // reserved code: accepted, dropped
    endcase
  end

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o && cls_keep;
  assign pop         = cmd_take_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls_cmd;
    end
  end

endmodule

>>> sv/dsm_back.sv
module dsm_back #(
  parameter int unsigned STACK_DEPTH = dsm_pkg::DefStackDepth,
  parameter int unsigned VALUE_WIDTH = dsm_pkg::DefValueWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  dsm_pkg::cmd_t                cmd_i,
  output logic                         cmd_take_o,
  output logic                         result_valid_o,
  output logic                         stack_id_o,
  output logic [dsm_pkg::ValueInW-1:0] element_value_o,
  output logic                         stack_empty_o,
  output logic                         last_of_dump_o
);
  import dsm_pkg::*;

  localparam int unsigned IdxW  = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = IdxW + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } st_e;

  st_e             state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            sel_q, sel_d;
  logic [CntW-1:0] cnt_q [2];
  logic [CntW-1:0] cnt_d [2];
  logic [CntW-1:0] cur_cnt;

  // Both stacks share one memory; address is {stack, index}.
  logic [VALUE_WIDTH-1:0] mem [2**AddrW];
  logic                   we, re;
  logic [AddrW-1:0]       waddr, raddr;
  logic [VALUE_WIDTH-1:0] wdata, rd_data_q;
  logic [MaxValueW-1:0]   wr_ext, rd_ext;

  logic out_vld_q, out_vld_d;
  logic out_sel_q, out_sel_d;
  logic out_empty_q, out_empty_d;
  logic out_last_q, out_last_d;

  assign cur_cnt = cnt_q[cmd_i.sel];
  assign wr_ext  = MaxValueW'(cmd_i.value);
  assign wdata   = wr_ext[VALUE_WIDTH-1:0];
  assign rd_ext  = MaxValueW'(rd_data_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    sel_d       = sel_q;
    cnt_d       = cnt_q;
    cmd_take_o  = 1'b0;
    we          = 1'b0;
    waddr       = {cmd_i.sel, cur_cnt[IdxW-1:0]};
    re          = 1'b0;
    raddr       = {sel_q, idx_q};
    out_vld_d   = 1'b0;
    out_sel_d   = sel_q;
    out_empty_d = 1'b0;
    out_last_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          case (cmd_i.kind)
            CMD_PUSH: begin
              if (cur_cnt < CntW'(STACK_DEPTH)) begin  // full: drop
                we                = 1'b1;
                cnt_d[cmd_i.sel]  = cur_cnt + 1'b1;
              end
            end
            CMD_POP: begin
              if (cur_cnt != '0) begin
                cnt_d[cmd_i.sel] = cur_cnt - 1'b1;
              end
            end
            CMD_DUMP: begin
              if (cur_cnt == '0) begin
                out_vld_d   = 1'b1;
                out_sel_d   = cmd_i.sel;
                out_empty_d = 1'b1;
                out_last_d  = 1'b1;
              end else begin
                state_d = ST_DUMP;
                idx_d   = '0;
                sel_d   = cmd_i.sel;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DUMP: begin
        // one read per cycle; data lands with the output strobe
        re         = 1'b1;
        out_vld_d  = 1'b1;
        out_sel_d  = sel_q;
        out_last_d = (CntW'(idx_q) + 1'b1 == cnt_q[sel_q]);
        if (out_last_d) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      sel_q     <= 1'b0;
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      sel_q     <= sel_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sel_q   <= out_sel_d;
    out_empty_q <= out_empty_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_q <= mem[raddr];
    end
  end

  assign result_valid_o  = out_vld_q;
  assign stack_id_o      = out_sel_q;
  assign stack_empty_o   = out_empty_q;
  assign last_of_dump_o  = out_last_q;
  assign element_value_o = out_empty_q ? '0 : rd_ext[ValueInW-1:0];

endmodule
